FILE: src/dsmc_pkg.sv
// ----------------------------------------------------------------------------
// Digit-sum multiple counter package
// Shared widths, constants, state encoding and the per-cell control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package dsmc_pkg;

    // Largest supported modulus, which is also the number of remainder cells.
    localparam int MAX_MODULUS = 128;
    localparam int IDX_W       = (MAX_MODULUS > 1) ? $clog2(MAX_MODULUS) : 1;
    localparam int MOD_W       = $clog2(MAX_MODULUS + 1);
    localparam int CFG_W       = 8;
    localparam int CMP_W       = (CFG_W > MOD_W) ? CFG_W : MOD_W;

    localparam int DIGIT_W = 4;
    localparam int CNT_W   = 30;

    localparam logic [CNT_W-1:0]   PRIME     = CNT_W'(1000000007);
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);

    // One window step per possible digit value.
    localparam int STEPS  = 10;
    localparam int STEP_W = $clog2(STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_ACCUM,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic             step;
        logic             first;
        logic             commit;
        logic             clear;
        logic             hit_en;
        logic [IDX_W-1:0] ptr;
        logic [MOD_W-1:0] modulus;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: src/dsmc_if.sv
// ----------------------------------------------------------------------------
// Digit-sum multiple counter channels
// Valid/ready channels for digits, results and the modulus register.
// ----------------------------------------------------------------------------
`default_nettype none

interface dsmc_in_if;
    logic                         valid;
    logic                         ready;
    logic [dsmc_pkg::DIGIT_W-1:0] digit_value;
    logic                         last_digit;

    modport source (output valid, output digit_value, output last_digit, input ready);
    modport sink   (input valid, input digit_value, input last_digit, output ready);
endinterface

interface dsmc_out_if;
    logic                       valid;
    logic                       ready;
    logic [dsmc_pkg::CNT_W-1:0] count_result;

    modport source (output valid, output count_result, input ready);
    modport sink   (input valid, input count_result, output ready);
endinterface

interface dsmc_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [dsmc_pkg::CFG_W-1:0] modulus;

    modport source (output valid, output modulus, input ready);
    modport sink   (input valid, input modulus, output ready);
endinterface

`default_nettype wire

FILE: src/digit_sum_multiple_counter_core.sv
// ----------------------------------------------------------------------------
// Digit-sum multiple counter
// Counts 1..R with digit sum divisible by the modulus, modulo 1e9+7.
// ----------------------------------------------------------------------------
//   Port      Dir   Beat payload                   Notes
//   i_digit   in    digit_value[3:0], last_digit   one decimal digit of R, MSD first
//   o_count   out   count_result[29:0]             one beat per bound
//   i_cfg     in    modulus[7:0]                   write only while idle
//
// A digit passes through the accept state, a remainder check and ten
// window steps in which every cell adds its ring neighbor. A modulus change
// may need extra subtractions in the remainder check; after the last digit a
// finish state forms the result. Reset clears all cells.
// The result sits in an output register, so a stalled o_count holds up only
// the finish state of the next bound.
// ----------------------------------------------------------------------------
`default_nettype none

module digit_sum_multiple_counter_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dsmc_in_if.sink    i_digit,
    dsmc_out_if.source o_count,
    dsmc_cfg_if.sink   i_cfg
);

    dsmc_pkg::t_state r_state, n_state;

    logic [dsmc_pkg::CFG_W-1:0]   r_modulus;
    logic [dsmc_pkg::DIGIT_W-1:0] r_digit, n_digit;
    logic                         r_last, n_last;
    logic [dsmc_pkg::IDX_W-1:0]   r_tight, n_tight;
    logic [dsmc_pkg::IDX_W-1:0]   r_ptr, n_ptr;
    logic [dsmc_pkg::STEP_W-1:0]  r_step, n_step;
    logic                         r_out_valid, n_out_valid;
    logic [dsmc_pkg::CNT_W-1:0]   r_count, n_count;

    logic [dsmc_pkg::CMP_W-1:0]   w_cfg_ext;
    logic [dsmc_pkg::MOD_W-1:0]   w_mod_eff;
    logic [dsmc_pkg::MOD_W-1:0]   w_tight_ext;
    logic                         w_need_reduce;
    logic [dsmc_pkg::IDX_W-1:0]   w_ptr_inc;
    logic                         w_hit_en;
    logic                         w_last_step;
    logic                         w_out_free;
    logic                         w_in_ready;
    logic                         w_accept;
    logic                         w_cfg_ready;
    logic [dsmc_pkg::CNT_W-1:0]   w_head;
    logic [dsmc_pkg::CNT_W-1:0]   w_total;
    logic [dsmc_pkg::CNT_W-1:0]   w_result;
    dsmc_pkg::t_cell_ctrl         w_ctrl;

    // Modulus zero acts as one; larger values saturate at the cell count.
    always_comb begin
        w_cfg_ext = dsmc_pkg::CMP_W'(r_modulus);
        if (w_cfg_ext == '0) begin
            w_mod_eff = dsmc_pkg::MOD_W'(1);
        end else if (w_cfg_ext > dsmc_pkg::CMP_W'(dsmc_pkg::MAX_MODULUS)) begin
            w_mod_eff = dsmc_pkg::MOD_W'(dsmc_pkg::MAX_MODULUS);
        end else begin
            w_mod_eff = dsmc_pkg::MOD_W'(w_cfg_ext);
        end
    end

    assign w_tight_ext   = dsmc_pkg::MOD_W'(r_tight);
    assign w_need_reduce = w_tight_ext >= w_mod_eff;
    assign w_ptr_inc     = ((dsmc_pkg::MOD_W'(r_ptr) + dsmc_pkg::MOD_W'(1)) == w_mod_eff)
                         ? '0 : r_ptr + dsmc_pkg::IDX_W'(1);
    assign w_hit_en      = dsmc_pkg::DIGIT_W'(r_step) < r_digit;
    assign w_last_step   = r_step == dsmc_pkg::STEP_W'(dsmc_pkg::STEPS - 1);
    assign w_out_free    = !r_out_valid || o_count.ready;
    assign w_accept      = i_digit.valid && w_in_ready;
    // The modulus may only change between digits, never during a window update.
    assign w_cfg_ready   = r_state == dsmc_pkg::S_IDLE;

    // Add one when R qualifies itself, remove the number zero.
    assign w_total  = w_head + dsmc_pkg::CNT_W'(r_tight == '0);
    assign w_result = (w_total == '0) ? dsmc_pkg::PRIME - dsmc_pkg::CNT_W'(1)
                                      : w_total - dsmc_pkg::CNT_W'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dsmc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = dsmc_pkg::S_REDUCE;
                end
            end
            dsmc_pkg::S_REDUCE: begin
                if (!w_need_reduce) begin
                    n_state = dsmc_pkg::S_ACCUM;
                end
            end
            dsmc_pkg::S_ACCUM: begin
                if (w_last_step) begin
                    n_state = r_last ? dsmc_pkg::S_FINISH : dsmc_pkg::S_IDLE;
                end
            end
            dsmc_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = dsmc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dsmc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_digit     = r_digit;
        n_last      = r_last;
        n_tight     = r_tight;
        n_ptr       = r_ptr;
        n_step      = r_step;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_count.ready;
        w_in_ready  = 1'b0;

        w_ctrl         = '0;
        w_ctrl.ptr     = r_ptr;
        w_ctrl.modulus = w_mod_eff;

        unique case (r_state)
            dsmc_pkg::S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_digit.valid) begin
                    n_digit = (i_digit.digit_value > dsmc_pkg::DIGIT_MAX)
                            ? dsmc_pkg::DIGIT_MAX : i_digit.digit_value;
                    n_last  = i_digit.last_digit;
                end
            end
            dsmc_pkg::S_REDUCE: begin
                // Only needed after the modulus has changed within a bound.
                if (w_need_reduce) begin
                    n_tight = dsmc_pkg::IDX_W'(w_tight_ext - w_mod_eff);
                end else begin
                    n_ptr  = r_tight;
                    n_step = '0;
                end
            end
            dsmc_pkg::S_ACCUM: begin
                w_ctrl.step   = 1'b1;
                w_ctrl.first  = r_step == '0;
                w_ctrl.hit_en = w_hit_en;
                w_ctrl.commit = w_last_step;
                if (w_hit_en) begin
                    n_ptr = w_ptr_inc;
                end
                n_step = r_step + dsmc_pkg::STEP_W'(1);
                if (w_last_step) begin
                    n_tight = w_hit_en ? w_ptr_inc : r_ptr;
                end
            end
            dsmc_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_count      = w_result;
                    n_out_valid  = 1'b1;
                    n_tight      = '0;
                    w_ctrl.clear = 1'b1;
                end
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    dsmc_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_head  (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsmc_pkg::S_IDLE;
            r_modulus   <= dsmc_pkg::CFG_W'(1);
            r_tight     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tight     <= n_tight;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && w_cfg_ready) begin
                r_modulus <= i_cfg.modulus;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
        r_last  <= n_last;
        r_ptr   <= n_ptr;
        r_step  <= n_step;
        r_count <= n_count;
    end

    assign i_digit.ready        = w_in_ready;
    assign i_cfg.ready          = w_cfg_ready;
    assign o_count.valid        = r_out_valid;
    assign o_count.count_result = r_count;

endmodule

`default_nettype wire

FILE: src/dsmc_cell.sv
// ----------------------------------------------------------------------------
// Remainder cell
// Holds the below-bound count for one remainder and accumulates the window.
// ----------------------------------------------------------------------------
`default_nettype none

module dsmc_cell (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [dsmc_pkg::IDX_W-1:0]   i_index,
    input  wire dsmc_pkg::t_cell_ctrl         i_ctrl,
    input  wire logic [dsmc_pkg::CNT_W-1:0]   i_left,
    output logic      [dsmc_pkg::CNT_W-1:0]   o_val
);

    logic [dsmc_pkg::CNT_W-1:0] r_val, n_val;
    logic [dsmc_pkg::CNT_W-1:0] r_acc, n_acc;
    logic                       w_active;
    logic                       w_hit;
    logic [dsmc_pkg::CNT_W:0]   w_sum;
    logic [dsmc_pkg::CNT_W:0]   w_wrap;
    logic [dsmc_pkg::CNT_W-1:0] w_mod;

    assign w_active = dsmc_pkg::MOD_W'(i_index) < i_ctrl.modulus;
    assign w_hit    = i_ctrl.hit_en && (i_index == i_ctrl.ptr);

    // Both counts are below the prime and the hit adds at most one, so one conditional subtract reduces the sum.
    assign w_sum  = {1'b0, (i_ctrl.first ? '0 : r_acc)} + {1'b0, r_val}
                  + (dsmc_pkg::CNT_W + 1)'(w_hit);
    assign w_wrap = w_sum - {1'b0, dsmc_pkg::PRIME};
    assign w_mod  = (w_sum >= {1'b0, dsmc_pkg::PRIME}) ? w_wrap[dsmc_pkg::CNT_W-1:0]
                                                       : w_sum[dsmc_pkg::CNT_W-1:0];

    always_comb begin
        n_val = r_val;
        n_acc = r_acc;
        if (i_ctrl.clear) begin
            n_val = '0;
        end else if (i_ctrl.step) begin
            n_acc = w_mod;
            // Values rotate around the ring until the window is complete.
            if (i_ctrl.commit) begin
                n_val = w_active ? w_mod : '0;
            end else begin
                n_val = i_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else begin
            r_val <= n_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_val = r_val;

endmodule

`default_nettype wire

FILE: src/dsmc_row.sv
// ----------------------------------------------------------------------------
// Remainder cell ring
// One cell per remainder; the ring closes at the active modulus.
// ----------------------------------------------------------------------------
`default_nettype none

module dsmc_row (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire dsmc_pkg::t_cell_ctrl       i_ctrl,
    output logic      [dsmc_pkg::CNT_W-1:0] o_head
);

    logic [dsmc_pkg::CNT_W-1:0] w_val  [dsmc_pkg::MAX_MODULUS];
    logic [dsmc_pkg::CNT_W-1:0] w_left [dsmc_pkg::MAX_MODULUS];
    logic [dsmc_pkg::IDX_W-1:0] w_wrap_idx;

    // The cell at modulus minus one feeds cell zero.
    assign w_wrap_idx = dsmc_pkg::IDX_W'(i_ctrl.modulus - dsmc_pkg::MOD_W'(1));

    for (genvar g = 0; g < dsmc_pkg::MAX_MODULUS; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g] = w_val[w_wrap_idx];
        end else begin : g_body
            assign w_left[g] = w_val[g-1];
        end

        dsmc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (dsmc_pkg::IDX_W'(g)),
            .i_ctrl  (i_ctrl),
            .i_left  (w_left[g]),
            .o_val   (w_val[g])
        );
    end

    assign o_head = w_val[0];

endmodule

`default_nettype wire

FILE: src/dsmc_checker.sv
// ----------------------------------------------------------------------------
// Digit-sum multiple counter checker
// Port-level properties of the counter core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module dsmc_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [dsmc_pkg::CNT_W-1:0] i_out_count
);

    // Reset drops any pending result.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result still valid after reset");

    // Every delivered count is already reduced by the prime.
    a_count_reduced: assert property (@(posedge i_clk)
        i_out_valid |-> (i_out_count < dsmc_pkg::PRIME))
        else $error("count not reduced modulo the prime");

    // A digit beat starts a multi-cycle update, so the input closes right after.
    a_busy_after_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("digit accepted while window update still running");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_count)))
        else $error("stalled result beat changed");

endmodule

bind digit_sum_multiple_counter_core dsmc_checker u_dsmc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_digit.valid),
    .i_in_ready  (i_digit.ready),
    .i_out_valid (o_count.valid),
    .i_out_ready (o_count.ready),
    .i_out_count (o_count.count_result)
);

`default_nettype wire
